/* rtl/core/mti_pkg.sv */
package mti_pkg;

  localparam int NUM_AXES = 6;
  localparam int OP_W     = 2;
  localparam int AXIS_W   = 3;
  localparam int SLOT_W   = 4;
  localparam int TADDR_W  = 16;
  localparam int VAL_W    = 32;
  localparam int SIZE_W   = 5;
  localparam int FRAC_W   = 17;
  localparam int CORNER_W = 6;
  localparam int ACC_W    = 56;

  localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(65536);

  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OP_W-1:0] OP_BP_WR  = 2'd1;
  localparam logic [OP_W-1:0] OP_TBL_WR = 2'd2;

  typedef enum logic [3:0] {
    L_IDLE,
    L_FIRST,
    L_LAST,
    L_SCAN,
    L_LO,
    L_HI,
    L_FRAC,
    L_DIV,
    L_DONE
  } lane_state_t;

  typedef enum logic [1:0] {
    T_IDLE,
    T_LANES,
    T_MERGE,
    T_PUSH
  } top_state_t;

endpackage

/* rtl/core/mti_lane.sv */
module mti_lane
  import mti_pkg::*;
#(
  parameter int MAX_POINTS = 16,
  localparam int CW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
  localparam int NW = $clog2(MAX_POINTS + 1)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    bp_we,
  input  logic [SLOT_W-1:0]       bp_slot,
  input  logic [VAL_W-1:0]        bp_data,
  input  logic                    start,
  input  logic signed [VAL_W-1:0] coord,
  input  logic [NW-1:0]           npts,
  output logic                    busy,
  output logic [CW-1:0]           cell_idx,
  output logic [FRAC_W-1:0]       frac
);

  logic signed [VAL_W-1:0] bp [MAX_POINTS];
  logic [31:0]             slot_ext;

  lane_state_t state, state_next;

  logic signed [VAL_W-1:0] x, first, prev, lo, hi, bp_rd;
  logic [CW-1:0]           idx, loc, rd_idx, nm1, nm2;
  logic [33:0]             rem, sh;
  logic [32:0]             den;
  logic [14:0]             q;
  logic [3:0]              cnt;
  logic signed [32:0]      d_num, d_den;
  logic                    ge, hit;

  assign slot_ext = 32'(bp_slot);

  always_ff @(posedge clk) begin
    if (bp_we && (slot_ext < 32'(MAX_POINTS))) begin
      bp[slot_ext[CW-1:0]] <= bp_data;
    end
  end

  assign nm1   = CW'(npts - NW'(1));
  assign nm2   = CW'(npts - NW'(2));
  assign bp_rd = bp[rd_idx];
  assign d_num = {x[VAL_W-1], x} - {lo[VAL_W-1], lo};
  assign d_den = {hi[VAL_W-1], hi} - {lo[VAL_W-1], lo};
  assign sh    = {rem[32:0], 1'b0};
  assign ge    = (sh >= {1'b0, den});
  assign hit   = (x >= prev) && (x < bp_rd);

  always_comb begin
    rd_idx = '0;
    unique case (state)
      L_LAST:  rd_idx = nm1;
      L_SCAN:  rd_idx = idx;
      L_LO:    rd_idx = loc;
      L_HI:    rd_idx = CW'(loc + 1'b1);
      default: rd_idx = '0;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      L_IDLE:  if (start) state_next = (npts <= NW'(1)) ? L_DONE : L_FIRST;
      L_FIRST: state_next = L_LAST;
      L_LAST: begin
        if (x <= first || x >= bp_rd) state_next = L_LO;
        else state_next = L_SCAN;
      end
      L_SCAN:  if (hit || idx == nm1) state_next = L_LO;
      L_LO:    state_next = L_HI;
      L_HI:    state_next = L_FRAC;
      L_FRAC: begin
        if (x <= lo || x >= hi || d_den <= 0) state_next = L_DONE;
        else state_next = L_DIV;
      end
      L_DIV:   if (cnt == 4'd15) state_next = L_DONE;
      L_DONE:  state_next = L_IDLE;
      default: state_next = L_IDLE;
    endcase
  end

  assign busy     = (state != L_IDLE);
  assign cell_idx = loc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // cell and fraction hold while idle so the merge can read them
  always_ff @(posedge clk) begin
    case (state)
      L_IDLE: begin
        if (start) begin
          x    <= coord;
          loc  <= '0;
          frac <= '0;
        end
      end
      L_FIRST: first <= bp_rd;
      L_LAST: begin
        prev <= first;
        idx  <= CW'(1);
        if (x <= first) loc <= '0;
        else loc <= nm2;
      end
      L_SCAN: begin
        prev <= bp_rd;
        idx  <= CW'(idx + 1'b1);
        if (hit) loc <= CW'(idx - 1'b1);
        else loc <= nm2;
      end
      L_LO: lo <= bp_rd;
      L_HI: hi <= bp_rd;
      L_FRAC: begin
        rem <= {1'b0, d_num};
        den <= d_den;
        cnt <= '0;
        if (x <= lo) frac <= '0;
        else if (x >= hi) frac <= FRAC_ONE;
        else frac <= '0;
      end
      L_DIV: begin
        rem  <= ge ? (sh - {1'b0, den}) : sh;
        q    <= {q[13:0], ge};
        cnt  <= cnt + 4'd1;
        frac <= {1'b0, q, ge};
      end
      default: ;
    endcase
  end

endmodule

/* rtl/core/mti_merge.sv */
module mti_merge
  import mti_pkg::*;
#(
  parameter int MAX_POINTS  = 16,
  parameter int TABLE_DEPTH = 65536,
  parameter int DATA_WIDTH  = 32,
  localparam int CW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
  localparam int NW = $clog2(MAX_POINTS + 1),
  localparam int AW = $clog2(TABLE_DEPTH)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               tbl_we,
  input  logic [TADDR_W-1:0] tbl_addr,
  input  logic [VAL_W-1:0]   tbl_data,
  input  logic               start,
  input  logic [CW-1:0]      cell_idx [NUM_AXES],
  input  logic [FRAC_W-1:0]  frac [NUM_AXES],
  input  logic [NW-1:0]      npts [NUM_AXES],
  output logic               done,
  output logic [VAL_W-1:0]   result
);

  localparam int OUT_BITS = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
  localparam logic signed [39:0] HI_LIM = (40'sd1 <<< (OUT_BITS - 1)) - 40'sd1;
  localparam logic signed [39:0] LO_LIM = -HI_LIM - 40'sd1;

  logic signed [VAL_W-1:0] tbl [TABLE_DEPTH];
  logic [31:0]             wa_ext;

  logic                issuing;
  logic [CORNER_W-1:0] corner;

  // one stage per axis: weight and address build up corner by corner
  logic                st_v    [NUM_AXES];
  logic [FRAC_W-1:0]   st_w    [NUM_AXES];
  logic [AW-1:0]       st_addr [NUM_AXES];
  logic [CORNER_W-1:0] st_cn   [NUM_AXES];

  logic                src_v    [NUM_AXES];
  logic [FRAC_W-1:0]   src_w    [NUM_AXES];
  logic [AW-1:0]       src_addr [NUM_AXES];
  logic [CORNER_W-1:0] src_cn   [NUM_AXES];
  logic [FRAC_W-1:0]   nx_w     [NUM_AXES];
  logic [AW-1:0]       nx_addr  [NUM_AXES];

  logic                    rd_v, pr_v, fin_v;
  logic [FRAC_W-1:0]       rd_w;
  logic signed [VAL_W-1:0] rd_data;
  logic signed [49:0]      prod;
  logic signed [ACC_W-1:0] acc;
  logic [CORNER_W-1:0]     acc_cnt;
  logic signed [39:0]      shifted;

  assign wa_ext = 32'(tbl_addr);

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl[wa_ext[AW-1:0]] <= tbl_data;
    end
    rd_data <= tbl[st_addr[NUM_AXES-1]];
  end

  always_comb begin
    logic                  up;
    logic [FRAC_W-1:0]     g;
    logic [2*FRAC_W-1:0]   wp;
    logic [AW+NW-1:0]      ap;
    logic [CW-1:0]         j;
    src_v[0]    = issuing;
    src_w[0]    = FRAC_ONE;
    src_addr[0] = '0;
    src_cn[0]   = corner;
    for (int a = 1; a < NUM_AXES; a++) begin
      src_v[a]    = st_v[a-1];
      src_w[a]    = st_w[a-1];
      src_addr[a] = st_addr[a-1];
      src_cn[a]   = st_cn[a-1];
    end
    for (int a = 0; a < NUM_AXES; a++) begin
      up = src_cn[a][NUM_AXES-1-a];
      g  = up ? frac[a] : FRAC_W'(FRAC_ONE - frac[a]);
      wp = src_w[a] * g;
      nx_w[a] = wp[FRAC_W+15:16];
      j  = CW'(cell_idx[a] + CW'(up && (npts[a] > NW'(1))));
      ap = src_addr[a] * npts[a];
      nx_addr[a] = AW'(ap + (AW+NW)'(j));
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < NUM_AXES; a++) begin
      st_w[a]    <= nx_w[a];
      st_addr[a] <= nx_addr[a];
      st_cn[a]   <= src_cn[a];
    end
    rd_w <= st_w[NUM_AXES-1];
    prod <= $signed({1'b0, rd_w}) * rd_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      issuing <= 1'b0;
      corner  <= '0;
      rd_v    <= 1'b0;
      pr_v    <= 1'b0;
      fin_v   <= 1'b0;
      acc_cnt <= '0;
      for (int a = 0; a < NUM_AXES; a++) st_v[a] <= 1'b0;
    end else begin
      for (int a = 0; a < NUM_AXES; a++) st_v[a] <= src_v[a];
      rd_v  <= st_v[NUM_AXES-1];
      pr_v  <= rd_v;
      fin_v <= pr_v && (acc_cnt == '1);
      if (start) begin
        issuing <= 1'b1;
        corner  <= '0;
        acc_cnt <= '0;
      end else begin
        if (issuing) begin
          corner <= corner + 1'b1;
          if (corner == '1) issuing <= 1'b0;
        end
        if (pr_v) acc_cnt <= acc_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) acc <= '0;
    else if (pr_v) acc <= acc + ACC_W'(prod);
  end

  // arithmetic shift floors toward minus infinity
  assign shifted = acc[ACC_W-1:16];
  assign done    = fin_v;

  always_comb begin
    if (shifted > HI_LIM) result = VAL_W'(HI_LIM);
    else if (shifted < LO_LIM) result = VAL_W'(LO_LIM);
    else result = VAL_W'(shifted);
  end

endmodule

/* rtl/core/multilinear_table_interp.sv */
// six-axis multilinear table interpolator
// input stream s_*: s_tuser carries the op (lookup, breakpoint write, table
// write); s_tdata carries addressing, the load value and six coordinates.
// output stream m_*: one word for every input word; m_tuser flags a lookup
// answer, m_tdata carries the Q16.16 result (zero for write acks).
// cfg_*: one write per cycle sets the number of breakpoints on an axis.
// a write's ack goes from the T_PUSH state into the output register, and
// the next word is taken only back in T_IDLE. a lookup runs the slowest
// lane's search (first and last breakpoint, then a linear scan), reads of
// the cell's two bounds, a bit-serial fraction divider, then 64 corners
// through the 6-stage weight/address pipeline, table read, multiply and accumulate.
// one item is in flight at a time; the 64 reads of the single table port
// set the floor of the lookup time.
// reset clears control and sets all axis sizes to 1; stores are undefined
// until written.
// a stalled receiver holds the output word; the next input word is still
// taken and worked on, and its result waits until the output frees.
// corner addresses wrap at TABLE_DEPTH, a power of two
module multilinear_table_interp
  import mti_pkg::*;
#(
  parameter int MAX_POINTS  = 16,
  parameter int TABLE_DEPTH = 65536,
  parameter int DATA_WIDTH  = 32
) (
  input  logic          clk,
  input  logic          rst,
  // configuration
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [4:0]    cfg_data,
  // input stream
  input  logic          s_tvalid,
  output logic          s_tready,
  // axis_select[2:0], point_slot[6:3], table_address[22:7],
  // load_value[54:23], coord_a..coord_f[86:55]..[246:215], zero pad[247]
  input  logic [247:0]  s_tdata,
  // op[1:0]
  input  logic [1:0]    s_tuser,
  // output stream
  output logic          m_tvalid,
  input  logic          m_tready,
  // result_value[31:0]
  output logic [31:0]   m_tdata,
  // is_lookup[0]
  output logic          m_tuser
);

  localparam int CW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int NW = $clog2(MAX_POINTS + 1);

  // input fields
  logic [OP_W-1:0]    op;
  logic [AXIS_W-1:0]  axis_select;
  logic [SLOT_W-1:0]  point_slot;
  logic [TADDR_W-1:0] table_address;
  logic [VAL_W-1:0]   load_value;
  logic signed [VAL_W-1:0] coord [NUM_AXES];

  assign op            = s_tuser;
  assign axis_select   = s_tdata[2:0];
  assign point_slot    = s_tdata[6:3];
  assign table_address = s_tdata[22:7];
  assign load_value    = s_tdata[54:23];
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      coord[a] = s_tdata[55 + a*VAL_W +: VAL_W];
    end
  end

  // axis sizes, clamped to 1..MAX_POINTS
  logic [SIZE_W-1:0] size_axis [NUM_AXES];
  logic [NW-1:0]     npts      [NUM_AXES];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < NUM_AXES; a++) size_axis[a] <= SIZE_W'(1);
    end else if (cfg_we && (32'(cfg_index) < NUM_AXES)) begin
      size_axis[cfg_index] <= cfg_data;
    end
  end

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      if (size_axis[a] == '0) npts[a] = NW'(1);
      else if (32'(size_axis[a]) > 32'(MAX_POINTS)) npts[a] = NW'(MAX_POINTS);
      else npts[a] = NW'(size_axis[a]);
    end
  end

  // control
  top_state_t state, state_next;
  logic accept, out_free, any_busy, merge_start, push;
  logic merge_done;
  logic [VAL_W-1:0] merge_res;
  logic [VAL_W-1:0] pend_res;
  logic             pend_lookup;

  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // search lanes, one per axis
  logic             lane_busy [NUM_AXES];
  logic [CW-1:0]    lane_cell [NUM_AXES];
  logic [FRAC_W-1:0] lane_frac [NUM_AXES];

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
    mti_lane #(.MAX_POINTS(MAX_POINTS)) u_lane (
      .clk      (clk),
      .rst      (rst),
      .bp_we    (accept && op == OP_BP_WR && axis_select == AXIS_W'(a)),
      .bp_slot  (point_slot),
      .bp_data  (load_value),
      .start    (accept && op == OP_LOOKUP),
      .coord    (coord[a]),
      .npts     (npts[a]),
      .busy     (lane_busy[a]),
      .cell_idx (lane_cell[a]),
      .frac     (lane_frac[a])
    );
  end

  always_comb begin
    any_busy = 1'b0;
    for (int a = 0; a < NUM_AXES; a++) any_busy = any_busy | lane_busy[a];
  end

  // corner blend over the value table
  mti_merge #(
    .MAX_POINTS  (MAX_POINTS),
    .TABLE_DEPTH (TABLE_DEPTH),
    .DATA_WIDTH  (DATA_WIDTH)
  ) u_merge (
    .clk      (clk),
    .rst      (rst),
    .tbl_we   (accept && op == OP_TBL_WR),
    .tbl_addr (table_address),
    .tbl_data (load_value),
    .start    (merge_start),
    .cell_idx (lane_cell),
    .frac     (lane_frac),
    .npts     (npts),
    .done     (merge_done),
    .result   (merge_res)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      T_IDLE:  if (accept) state_next = (op == OP_LOOKUP) ? T_LANES : T_PUSH;
      T_LANES: if (!any_busy) state_next = T_MERGE;
      T_MERGE: if (merge_done) state_next = T_PUSH;
      T_PUSH:  if (out_free) state_next = T_IDLE;
      default: state_next = T_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    s_tready    = 1'b0;
    merge_start = 1'b0;
    push        = 1'b0;
    unique case (state)
      T_IDLE:  s_tready = 1'b1;
      T_LANES: merge_start = !any_busy;
      T_PUSH:  push = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // pending result, held until the output register frees
  always_ff @(posedge clk) begin
    if (state == T_IDLE && accept) begin
      pend_res    <= '0;
      pend_lookup <= (op == OP_LOOKUP);
    end else if (state == T_MERGE && merge_done) begin
      pend_res <= merge_res;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (push) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      m_tdata <= pend_res;
      m_tuser <= pend_lookup;
    end
  end

endmodule

/* dv/tb_multilinear_table_interp.sv */
`timescale 1ns / 1ps

module tb_multilinear_table_interp;
  import mti_pkg::*;

  localparam int NPTS  = 16;
  localparam int TDEP  = 65536;
  localparam longint CYCLE_LIMIT = 4000000;

  typedef struct packed {
    logic [1:0]  op;
    logic [2:0]  axis;
    logic [3:0]  slot;
    logic [15:0] taddr;
    logic [31:0] val;
    logic [5:0][31:0] coord;
  } req_t;

  typedef struct packed {
    logic [31:0] value;
    logic        lookup;
  } ans_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [2:0] cfg_index = 0;
  logic [4:0] cfg_data = 0;
  logic s_tvalid = 0;
  logic s_tready;
  logic [247:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [31:0] m_tdata;
  logic m_tuser;

  multilinear_table_interp dut (.*);

  always #6 clk = ~clk;

  // testbench-side copy of the block state
  logic [31:0] bp_mem [NUM_AXES*NPTS];
  logic [31:0] tbl_mem [TDEP];
  logic [4:0]  axis_len [NUM_AXES];

  req_t pending_words[$];
  ans_t expected_answers[$];
  int   errors = 0;
  bit   quiet_tail = 0;    // no idling near the end
  int   hold_off = 0;      // long receiver stall, in cycles
  longint cycles = 0;

  function automatic longint sx(logic [31:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic int eff_len(int a);
    int n;
    n = axis_len[a];
    if (n < 1) n = 1;
    if (n > NPTS) n = NPTS;
    return n;
  endfunction

  // per-axis cell search and Q1.16 fraction
  function automatic void locate(input int a, input int n, input longint x,
                                 output int cell_idx, output longint frac);
    int loc;
    longint lo, hi;
    if (n <= 1) begin
      cell_idx = 0; frac = 0; return;
    end
    loc = n - 2;
    if (x <= sx(bp_mem[a*NPTS])) loc = 0;
    else if (x >= sx(bp_mem[a*NPTS+n-1])) loc = n - 2;
    else begin
      for (int i = 0; i + 1 < n; i++)
        if (x >= sx(bp_mem[a*NPTS+i]) && x < sx(bp_mem[a*NPTS+i+1])) begin
          loc = i; break;
        end
    end
    lo = sx(bp_mem[a*NPTS+loc]);
    hi = sx(bp_mem[a*NPTS+loc+1]);
    cell_idx = loc;
    if (x <= lo) frac = 0;
    else if (x >= hi) frac = 65536;
    else if (hi - lo <= 0) frac = 0;
    else frac = ((x - lo) * 65536) / (hi - lo);
  endfunction

  function automatic logic [31:0] interpolate(req_t r);
    int n [NUM_AXES];
    int cells [NUM_AXES];
    longint frac [NUM_AXES];
    longint w, addr, acc, res;
    int j;
    bit up;
    acc = 0;
    for (int a = 0; a < NUM_AXES; a++) begin
      n[a] = eff_len(a);
      locate(a, n[a], sx(r.coord[a]), cells[a], frac[a]);
    end
    for (int c = 0; c < 64; c++) begin
      w = 65536; addr = 0;
      for (int a = 0; a < NUM_AXES; a++) begin
        up = c[NUM_AXES-1-a];
        j = cells[a];
        if (up && n[a] > 1) j++;
        w = (w * (up ? frac[a] : 65536 - frac[a])) >>> 16;
        addr = addr * n[a] + j;
      end
      acc += w * sx(tbl_mem[addr % TDEP]);
    end
    if (acc >= 0) res = acc >>> 16;
    else res = -((-acc + 65535) >>> 16);
    if (res > 64'sh7FFFFFFF) res = 64'sh7FFFFFFF;
    if (res < -64'sh80000000) res = -64'sh80000000;
    return res[31:0];
  endfunction

  // update the copy and queue the answer when a word is accepted
  function automatic void predict(req_t r);
    ans_t e;
    e = '0;
    if (r.op == OP_LOOKUP) begin
      e.value = interpolate(r); e.lookup = 1;
    end else if (r.op == OP_BP_WR) begin
      if (r.axis < NUM_AXES) bp_mem[r.axis*NPTS + r.slot] = r.val;
    end else if (r.op == OP_TBL_WR) begin
      tbl_mem[r.taddr] = r.val;
    end
    expected_answers.push_back(e);
  endfunction

  function automatic logic [247:0] pack_req(req_t r);
    logic [247:0] d;
    d = '0;
    d[2:0] = r.axis; d[6:3] = r.slot; d[22:7] = r.taddr; d[54:23] = r.val;
    for (int a = 0; a < NUM_AXES; a++) d[55 + 32*a +: 32] = r.coord[a];
    return d;
  endfunction

  req_t cur_word;
  bit s_tready_seen = 0;
  int recv_gap = 0;

  // driver: one word from the queue, random gaps
  int send_gap = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (!s_tvalid || s_tready_seen) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          s_tvalid <= 0;
        end else if (pending_words.size() > 0) begin
          s_tvalid <= 1;
          s_tdata <= pack_req(pending_words[0]);
          s_tuser <= pending_words[0].op;
          cur_word <= pending_words.pop_front();
          if (!quiet_tail && $urandom_range(0, 7) == 0)
            send_gap <= $urandom_range(1, 12);
        end else s_tvalid <= 0;
      end
    end
  end

  // monitor: accept on input, check on output, receiver stalls
  always @(posedge clk) begin
    cycles <= cycles + 1;
    s_tready_seen <= !rst && s_tvalid && s_tready;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        predict(cur_word);
      end
      if (m_tvalid && m_tready) begin
        if (expected_answers.size() == 0) begin
          $error("unexpected output word value=%h lookup=%b", m_tdata, m_tuser);
          errors++;
        end else begin
          ans_t e;
          e = expected_answers.pop_front();
          if (m_tdata !== e.value) begin
            $error("result_value expected %h actual %h", e.value, m_tdata);
            errors++;
          end
          if (m_tuser !== e.lookup) begin
            $error("is_lookup expected %b actual %b", e.lookup, m_tuser);
            errors++;
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_tready <= 0;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      m_tready <= 0;
    end else begin
      m_tready <= 1;
      if (!quiet_tail && $urandom_range(0, 9) == 0) recv_gap <= $urandom_range(1, 12);
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_multilinear_table_interp: errors");
      $finish;
    end
  end

  // blank request and pushers for breakpoint and table writes
  function automatic req_t blank_req();
    req_t r;
    r = '0;
    return r;
  endfunction

  task automatic push_bp(int a, int s, logic [31:0] v);
    req_t r;
    r = blank_req(); r.op = OP_BP_WR; r.axis = 3'(a); r.slot = 4'(s); r.val = v;
    pending_words.push_back(r);
  endtask

  task automatic push_tbl(int addr, logic [31:0] v);
    req_t r;
    r = blank_req(); r.op = OP_TBL_WR; r.taddr = 16'(addr); r.val = v;
    pending_words.push_back(r);
  endtask

  function automatic logic [31:0] rand_coord(int a, int n);
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return 32'h8000_0000;
    if (k == 1) return 32'h7FFF_FFFF;
    if (k == 2) return $urandom();
    return 32'($signed(n * 65536)) - 32'($urandom_range(0, n * 65536 + 65536))
           + 32'sd0;
  endfunction

  task automatic push_lookup(logic [4:0] lens [NUM_AXES], bit wild);
    req_t r;
    r = blank_req(); r.op = OP_LOOKUP;
    // unused fields still toggle
    r.axis = 3'($urandom()); r.slot = 4'($urandom());
    r.taddr = 16'($urandom()); r.val = $urandom();
    for (int a = 0; a < NUM_AXES; a++)
      r.coord[a] = wild ? $urandom() : rand_coord(a, lens[a] > NPTS ? NPTS : lens[a]);
    pending_words.push_back(r);
  endtask

  task automatic wait_idle();
    while (pending_words.size() > 0 || s_tvalid || expected_answers.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_len(int idx, logic [4:0] v);
    @(negedge clk);
    cfg_we <= 1; cfg_index <= 3'(idx); cfg_data <= v; axis_len[idx] = v;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  // one phase: set sizes, load breakpoints and the used table region, run lookups
  task automatic run_phase(logic [4:0] lens [NUM_AXES], int lookups, bit ext_vals);
    int n [NUM_AXES];
    int span;
    logic [31:0] base;
    wait_idle();
    for (int a = 0; a < NUM_AXES; a++) write_len(a, lens[a]);
    span = 1;
    for (int a = 0; a < NUM_AXES; a++) begin
      n[a] = eff_len(a);
      span *= n[a];
      base = 0;
      for (int s = 0; s < n[a]; s++) begin
        push_bp(a, s, base);
        // mostly ascending, sometimes flat or descending steps
        case ($urandom_range(0, 9))
          0: base = base;
          1: base = base - $urandom_range(0, 65536);
          default: base = base + $urandom_range(1, 3 * 65536);
        endcase
      end
    end
    for (int i = 0; i < span; i++)
      push_tbl(i, ext_vals ? ($urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000)
                           : $urandom());
    for (int k = 0; k < lookups; k++) begin
      push_lookup(lens, $urandom_range(0, 9) == 0);
      if ($urandom_range(0, 7) == 0) begin
        // odd writes: ignored axis, op code 3
        req_t r;
        r = blank_req(); r.op = $urandom_range(0, 1) ? 2'd3 : OP_BP_WR;
        r.axis = 3'($urandom_range(6, 7)); r.slot = 4'($urandom()); r.val = $urandom();
        r.taddr = 16'($urandom()); r.coord = {$urandom(), $urandom(), $urandom(),
                                              $urandom(), $urandom(), $urandom()};
        pending_words.push_back(r);
      end
    end
  endtask

  initial begin
    logic [4:0] lens [NUM_AXES];
    for (int a = 0; a < NUM_AXES; a++) axis_len[a] = 1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // directed: all size one, then size 0 and size 31 (clamped), extreme values
    lens = '{1, 1, 1, 1, 1, 1};
    run_phase(lens, 4, 1);
    lens = '{0, 31, 2, 1, 16, 0};
    run_phase(lens, 8, 1);
    // long receiver stall while the sender keeps offering
    wait_idle();
    hold_off = 600;
    lens = '{2, 2, 2, 2, 2, 2};
    run_phase(lens, 10, 0);
    // random phases with small tables, size 0 now and then
    for (int p = 0; p < 8; p++) begin
      for (int a = 0; a < NUM_AXES; a++)
        lens[a] = ($urandom_range(0, 7) == 0) ? 5'd0 : 5'($urandom_range(1, 3));
      if (p >= 6) quiet_tail = 1;
      run_phase(lens, 30, $urandom_range(0, 7) == 0);
    end
    wait_idle();
    repeat (200) @(posedge clk);
    if (errors == 0) $display("tb_multilinear_table_interp: clean");
    else $display("tb_multilinear_table_interp: errors");
    $finish;
  end

endmodule

/* files.f */
rtl/core/mti_pkg.sv
rtl/core/mti_lane.sv
rtl/core/mti_merge.sv
rtl/core/multilinear_table_interp.sv
dv/tb_multilinear_table_interp.sv
